// ===== hw/rtl/vopf_pkg.sv =====
package vopf_pkg;

    localparam int ChanW  = 8;
    localparam int RowW   = 16;
    localparam int ColW   = 11;
    localparam int FwW    = 12;
    localparam int FhW    = 16;
    localparam int CfgW   = 16;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FwW-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FhW-1:0] FRAME_HEIGHT_RST = 16'd480;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic one_row;
        logic last_row;
        logic row_ge1;
        logic row_ge2;
    } flags_t;

    typedef struct packed {
        pix_t            pix;
        logic [RowW-1:0] row;
    } res_t;

    typedef struct packed {
        logic has_a;
        logic has_b;
        res_t a;
        res_t b;
    } pair_t;

endpackage

// ===== hw/rtl/vopf_ram.sv =====
module vopf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/vopf_front.sv =====
module vopf_front #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW = (CW + 1 > vopf_pkg::FwW) ? CW + 1 : vopf_pkg::FwW
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  vopf_pkg::pix_t             in_pix,
    input  logic [vopf_pkg::FwW-1:0]   frame_width,
    input  logic [vopf_pkg::FhW-1:0]   frame_height,
    output logic [CW-1:0]              rd_addr,
    output logic                       p1_valid,
    output vopf_pkg::pix_t             p1_pix,
    output logic [CW-1:0]              p1_col,
    output logic [vopf_pkg::RowW-1:0]  p1_row,
    output vopf_pkg::flags_t           p1_flags
);

    logic [CW-1:0]               col_reg, col_next;
    logic [vopf_pkg::RowW-1:0]   row_reg, row_next;
    logic                        p1_valid_reg;
    vopf_pkg::pix_t              p1_pix_reg;
    logic [CW-1:0]               p1_col_reg;
    logic [vopf_pkg::RowW-1:0]   p1_row_reg;
    vopf_pkg::flags_t            p1_flags_reg;

    logic [WW-1:0]               fw_ext, w_eff, col_plus;
    logic [vopf_pkg::FhW-1:0]    h_eff;
    logic [vopf_pkg::RowW:0]     row_plus;
    logic                        accept, wrap, last_row;
    vopf_pkg::flags_t            flags;

    always_comb begin
        fw_ext = WW'(frame_width);
        if (fw_ext == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        h_eff    = (frame_height == '0) ? vopf_pkg::FhW'(1) : frame_height;
        row_plus = {1'b0, row_reg} + (vopf_pkg::RowW + 1)'(1);
        last_row = row_plus >= {1'b0, h_eff};
        col_plus = WW'(col_reg) + WW'(1);
        wrap     = col_plus >= w_eff;
        accept   = adv && in_valid;

        flags.one_row  = h_eff == vopf_pkg::FhW'(1);
        flags.last_row = last_row;
        flags.row_ge1  = row_reg != '0;
        flags.row_ge2  = row_reg > vopf_pkg::RowW'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (wrap) begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[vopf_pkg::RowW-1:0];
            end else begin
                col_next = col_plus[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (adv) begin
                p1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_pix_reg   <= in_pix;
            p1_col_reg   <= col_reg;
            p1_row_reg   <= row_reg;
            p1_flags_reg <= flags;
        end
    end

    assign rd_addr  = col_reg;
    assign p1_valid = p1_valid_reg;
    assign p1_pix   = p1_pix_reg;
    assign p1_col   = p1_col_reg;
    assign p1_row   = p1_row_reg;
    assign p1_flags = p1_flags_reg;

endmodule

// ===== hw/rtl/vopf_core.sv =====
module vopf_core #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       p1_valid,
    input  vopf_pkg::pix_t             p1_pix,
    input  logic [CW-1:0]              p1_col,
    input  logic [vopf_pkg::RowW-1:0]  p1_row,
    input  vopf_pkg::flags_t           p1_flags,
    input  vopf_pkg::pix_t             ram_above,
    input  vopf_pkg::pix_t             ram_two,
    output logic                       wr_en,
    output logic [CW-1:0]              wr_addr,
    output vopf_pkg::pix_t             wr_one,
    output vopf_pkg::pix_t             wr_two,
    output logic                       p2_valid,
    output logic [CW-1:0]              p2_col,
    output vopf_pkg::pair_t            p2_pair
);

    logic                        p2_valid_reg;
    vopf_pkg::pix_t              p2_pix_reg, p2_above_reg, p2_two_reg;
    logic [CW-1:0]               p2_col_reg;
    logic [vopf_pkg::RowW-1:0]   p2_row_reg;
    vopf_pkg::flags_t            p2_flags_reg;

    logic                        hit;
    vopf_pkg::pix_t              above, two, two_mask;

    // previous item wrote this column on the edge that launched our read
    always_comb begin
        hit   = p2_valid_reg && (p2_col_reg == p1_col);
        above = hit ? p2_pix_reg   : ram_above;
        two   = hit ? p2_above_reg : ram_two;
    end

    assign wr_en   = adv && p1_valid;
    assign wr_addr = p1_col;
    assign wr_one  = p1_pix;
    assign wr_two  = above;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_pix_reg   <= p1_pix;
            p2_above_reg <= above;
            p2_two_reg   <= two;
            p2_col_reg   <= p1_col;
            p2_row_reg   <= p1_row;
            p2_flags_reg <= p1_flags;
        end
    end

    always_comb begin
        two_mask = p2_flags_reg.row_ge2 ? p2_two_reg : '0;
        p2_pair.has_a = p2_flags_reg.one_row || p2_flags_reg.row_ge1;
        p2_pair.has_b = !p2_flags_reg.one_row && p2_flags_reg.last_row;
        if (p2_flags_reg.one_row) begin
            p2_pair.a.pix = p2_pix_reg;
            p2_pair.a.row = '0;
        end else begin
            p2_pair.a.pix = vopf_pkg::pix_t'(p2_pix_reg | p2_above_reg | two_mask);
            p2_pair.a.row = p2_row_reg - vopf_pkg::RowW'(1);
        end
        p2_pair.b.pix = vopf_pkg::pix_t'(p2_pix_reg | p2_above_reg);
        p2_pair.b.row = p2_row_reg;
    end

    assign p2_valid = p2_valid_reg;
    assign p2_col   = p2_col_reg;

endmodule

// ===== hw/rtl/vopf_out.sv =====
module vopf_out #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        p2_valid,
    input  logic [CW-1:0]               p2_col,
    input  vopf_pkg::pair_t             p2_pair,
    output logic                        adv,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vopf_pkg::ChanW-1:0]  m_blue_out,
    output logic [vopf_pkg::ChanW-1:0]  m_green_out,
    output logic [vopf_pkg::ChanW-1:0]  m_red_out,
    output logic [vopf_pkg::RowW-1:0]   m_out_row,
    output logic [vopf_pkg::ColW-1:0]   m_out_col,
    output logic                        m_last_of_run
);

    logic              p3_valid_reg;
    logic              phase_reg, phase_next;
    vopf_pkg::pair_t   p3_pair_reg;
    logic [CW-1:0]     p3_col_reg;

    logic              show_a, done;
    vopf_pkg::res_t    shown;

    always_comb begin
        show_a = p3_pair_reg.has_a && !phase_reg;
        done   = m_ready && (!show_a || !p3_pair_reg.has_b);
        adv    = !p3_valid_reg || done;
        shown  = show_a ? p3_pair_reg.a : p3_pair_reg.b;

        phase_next = phase_reg;
        if (adv) begin
            phase_next = 1'b0;
        end else if (m_ready && show_a) begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (adv) begin
                p3_valid_reg <= p2_valid && (p2_pair.has_a || p2_pair.has_b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_pair_reg <= p2_pair;
            p3_col_reg  <= p2_col;
        end
    end

    assign m_valid       = p3_valid_reg;
    assign m_blue_out    = shown.pix.blue;
    assign m_green_out   = shown.pix.green;
    assign m_red_out     = shown.pix.red;
    assign m_out_row     = shown.row;
    assign m_out_col     = vopf_pkg::ColW'(p3_col_reg);
    assign m_last_of_run = !show_a || !p3_pair_reg.has_b;

endmodule

// ===== hw/rtl/vertical_or_pixel_filter.sv =====
// channel   dir   handshake           payload
// s_        in    s_valid / s_ready   s_blue_in, s_green_in, s_red_in
// m_        out   m_valid / m_ready   m_blue_out, m_green_out, m_red_out,
//                                     m_out_row, m_out_col, m_last_of_run
// cfg_      in    cfg_we              cfg_index, cfg_wdata
//
// one pixel per clock with m_ready high; a last-row pixel's first result holds s_ready low
// three register stages: counters with line store read, store data with bypass, output pair
// a taken request is registered in p1, then p2, then p3, which drives m_
// reset clears counters and pipeline valids and loads 640x480; line stores are not cleared
// a waiting result with m_ready low freezes every stage; s_ready follows it combinationally
module vertical_or_pixel_filter #(
    parameter int MAX_WIDTH = 2048,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [vopf_pkg::ChanW-1:0]     s_blue_in,
    input  logic [vopf_pkg::ChanW-1:0]     s_green_in,
    input  logic [vopf_pkg::ChanW-1:0]     s_red_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [vopf_pkg::ChanW-1:0]     m_blue_out,
    output logic [vopf_pkg::ChanW-1:0]     m_green_out,
    output logic [vopf_pkg::ChanW-1:0]     m_red_out,
    output logic [vopf_pkg::RowW-1:0]      m_out_row,
    output logic [vopf_pkg::ColW-1:0]      m_out_col,
    output logic                           m_last_of_run,
    input  logic                           cfg_we,
    input  logic [vopf_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vopf_pkg::CfgW-1:0]      cfg_wdata
);

    logic [vopf_pkg::FwW-1:0]    frame_width_reg;
    logic [vopf_pkg::FhW-1:0]    frame_height_reg;

    logic                        adv;
    vopf_pkg::pix_t              in_pix;
    logic [CW-1:0]               rd_addr;
    logic                        p1_valid;
    vopf_pkg::pix_t              p1_pix;
    logic [CW-1:0]               p1_col;
    logic [vopf_pkg::RowW-1:0]   p1_row;
    vopf_pkg::flags_t            p1_flags;
    vopf_pkg::pix_t              ram_above, ram_two;
    logic [$bits(vopf_pkg::pix_t)-1:0] one_rdata, two_rdata;
    logic                        wr_en;
    logic [CW-1:0]               wr_addr;
    vopf_pkg::pix_t              wr_one, wr_two;
    logic                        p2_valid;
    logic [CW-1:0]               p2_col;
    vopf_pkg::pair_t             p2_pair;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= vopf_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= vopf_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vopf_pkg::CFG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_wdata[vopf_pkg::FwW-1:0];
                end
                vopf_pkg::CFG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_wdata[vopf_pkg::FhW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign in_pix.blue  = s_blue_in;
    assign in_pix.green = s_green_in;
    assign in_pix.red   = s_red_in;
    assign s_ready      = adv;

    vopf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_valid),
        .in_pix       (in_pix),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .rd_addr      (rd_addr),
        .p1_valid     (p1_valid),
        .p1_pix       (p1_pix),
        .p1_col       (p1_col),
        .p1_row       (p1_row),
        .p1_flags     (p1_flags)
    );

    // line store of the row above
    vopf_ram #(.WIDTH($bits(vopf_pkg::pix_t)), .DEPTH(MAX_WIDTH)) u_row_one (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_one),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (one_rdata)
    );

    // line store of the row two above
    vopf_ram #(.WIDTH($bits(vopf_pkg::pix_t)), .DEPTH(MAX_WIDTH)) u_row_two (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_two),
        .re    (adv),
        .raddr (rd_addr),
        .rdata (two_rdata)
    );

    assign ram_above = vopf_pkg::pix_t'(one_rdata);
    assign ram_two   = vopf_pkg::pix_t'(two_rdata);

    vopf_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .p1_valid  (p1_valid),
        .p1_pix    (p1_pix),
        .p1_col    (p1_col),
        .p1_row    (p1_row),
        .p1_flags  (p1_flags),
        .ram_above (ram_above),
        .ram_two   (ram_two),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_one    (wr_one),
        .wr_two    (wr_two),
        .p2_valid  (p2_valid),
        .p2_col    (p2_col),
        .p2_pair   (p2_pair)
    );

    vopf_out #(.MAX_WIDTH(MAX_WIDTH)) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .p2_valid      (p2_valid),
        .p2_col        (p2_col),
        .p2_pair       (p2_pair),
        .adv           (adv),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_blue_out    (m_blue_out),
        .m_green_out   (m_green_out),
        .m_red_out     (m_red_out),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== hw/rtl/vopf_checker.sv =====
module vopf_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [vopf_pkg::ChanW-1:0]     s_blue_in,
    input  logic [vopf_pkg::ChanW-1:0]     s_green_in,
    input  logic [vopf_pkg::ChanW-1:0]     s_red_in,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [vopf_pkg::ChanW-1:0]     m_blue_out,
    input  logic [vopf_pkg::ChanW-1:0]     m_green_out,
    input  logic [vopf_pkg::ChanW-1:0]     m_red_out,
    input  logic [vopf_pkg::RowW-1:0]      m_out_row,
    input  logic [vopf_pkg::ColW-1:0]      m_out_col,
    input  logic                           m_last_of_run,
    input  logic                           cfg_we,
    input  logic [vopf_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vopf_pkg::CfgW-1:0]      cfg_wdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_blue_out) && $stable(m_green_out) && $stable(m_red_out)
            && $stable(m_last_of_run))
        else $error("stalled result changed");

    // first of a pair is followed at once by its own row in the same column
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run
            && $stable(m_out_col) && (m_out_row == $past(m_out_row) + 16'd1))
        else $error("second result of a last-row pixel missing");

    // no new request while the first of a pair is shown
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("request taken while a result pair is pending");

    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind vertical_or_pixel_filter vopf_checker u_vopf_checker (.*);
